// ----- hdl/cmar_pkg.sv -----
package cmar_pkg;

  // Field widths of the channels and of the settings registers.
  localparam int RAW_W  = 10;
  localparam int GAIN_W = 24;
  localparam int OFF_W  = 32;
  localparam int INTV_W = 16;
  localparam int AVG_W  = 32;
  localparam int CFG_W  = 32;

  // Settings register map.
  typedef enum logic [1:0] {
    CFG_GAIN     = 2'd0,
    CFG_OFFSET   = 2'd1,
    CFG_INTERVAL = 2'd2,
    CFG_ENABLE   = 2'd3
  } cfg_index_t;

  // Values the settings take at reset.
  localparam logic signed [GAIN_W-1:0] GAIN_RESET     = 24'sd65536;
  localparam logic signed [OFF_W-1:0]  OFFSET_RESET   = 32'sd0;
  localparam logic [INTV_W-1:0]        INTERVAL_RESET = 16'd250;
  localparam logic                     ENABLE_RESET   = 1'b1;

  // Calibration settings as the scaling pipeline captures them.
  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic signed [OFF_W-1:0]  offset;
  } cal_t;

endpackage

// ----- hdl/cmar_tick_if.sv -----
interface cmar_tick_if;
  logic                         valid;
  logic                         ready;
  logic [cmar_pkg::RAW_W-1:0]   raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

// ----- hdl/cmar_report_if.sv -----
interface cmar_report_if;
  logic                              valid;
  logic                              ready;
  logic signed [cmar_pkg::AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

// ----- hdl/cmar_calib.sv -----
// Scaling pipeline: |sum * gain| / WINDOW with truncation toward zero, sign restored,
// offset added and the result clamped to 32 bits. The division by WINDOW is a
// multiplication by a rounded-up reciprocal, split into four partial products.
module cmar_calib #(
  parameter int WINDOW = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   in_valid,
  input  logic [$clog2(WINDOW*1023+1)-1:0]       sum,
  input  cmar_pkg::cal_t                         cal,
  output logic                                   out_valid,
  output logic signed [cmar_pkg::AVG_W-1:0]      average
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = $clog2(WINDOW*1023+1);
  localparam int PW    = SUM_W + cmar_pkg::GAIN_W;
  localparam int N     = SUM_W + cmar_pkg::GAIN_W - 1;
  localparam int H     = (N + 1) / 2;
  localparam int TW    = 2 * N + 1;
  localparam int Q_W   = N + 1 - IDX_W;
  localparam int VW    = Q_W + 2;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << (N + IDX_W)) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [N:0] RECIP = RECIP64[N:0];
  localparam logic [H-1:0]   RECIP_LO = RECIP[H-1:0];
  localparam logic [N-H:0]   RECIP_HI = RECIP[N:H];
  localparam logic signed [VW-1:0] AVG_MAX = VW'(32'sh7FFF_FFFF);
  localparam logic signed [VW-1:0] AVG_MIN = VW'(32'sh8000_0000);

  // Stage 1: captured operands.
  logic                                v1;
  logic [SUM_W-1:0]                    sum1;
  logic [cmar_pkg::GAIN_W-1:0]         gabs1;
  logic                                neg1;
  logic signed [cmar_pkg::OFF_W-1:0]   off1;
  // Stage 2: product magnitude.
  logic                                v2;
  logic [N-1:0]                        mag2;
  logic                                neg2;
  logic signed [cmar_pkg::OFF_W-1:0]   off2;
  // Stage 3: partial products of the reciprocal multiplication.
  logic                                v3;
  logic [2*N-2*H:0]                    hh3;
  logic [N-1:0]                        hl3;
  logic [N:0]                          lh3;
  logic [2*H-1:0]                      ll3;
  logic                                neg3;
  logic signed [cmar_pkg::OFF_W-1:0]   off3;
  // Stage 4: quotient.
  logic                                v4;
  logic [Q_W-1:0]                      q4;
  logic                                neg4;
  logic signed [cmar_pkg::OFF_W-1:0]   off4;

  logic [cmar_pkg::GAIN_W-1:0]         gabs;
  logic [PW-1:0]                       prod;
  logic [N+1:0]                        mid;
  logic [TW-1:0]                       total;
  logic signed [Q_W:0]                 sq;
  logic signed [VW-1:0]                val;
  logic signed [cmar_pkg::AVG_W-1:0]   sat;

  always_comb begin
    gabs  = cal.gain[cmar_pkg::GAIN_W-1] ? (~cal.gain + 1'b1) : cal.gain;
    prod  = PW'(sum1) * PW'(gabs1);
    mid   = (N+2)'(hl3) + (N+2)'(lh3);
    total = {hh3, ll3} + (TW'(mid) << H);
    sq    = neg4 ? -$signed({1'b0, q4}) : $signed({1'b0, q4});
    val   = VW'(sq) + VW'(off4);
    if (val > AVG_MAX) begin
      sat = AVG_MAX[cmar_pkg::AVG_W-1:0];
    end else if (val < AVG_MIN) begin
      sat = AVG_MIN[cmar_pkg::AVG_W-1:0];
    end else begin
      sat = val[cmar_pkg::AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum1    <= sum;
      gabs1   <= gabs;
      neg1    <= cal.gain[cmar_pkg::GAIN_W-1];
      off1    <= cal.offset;

      mag2    <= prod[N-1:0];
      neg2    <= neg1;
      off2    <= off1;

      hh3     <= mag2[N-1:H] * RECIP_HI;
      hl3     <= mag2[N-1:H] * RECIP_LO;
      lh3     <= mag2[H-1:0] * RECIP_HI;
      ll3     <= mag2[H-1:0] * RECIP_LO;
      neg3    <= neg2;
      off3    <= off2;

      q4      <= total[TW-1 -: Q_W];
      neg4    <= neg3;
      off4    <= off3;

      average <= sat;
    end
  end

`ifndef SYNTHESIS
  a_out_from_stage4: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v4))
    else $error("result appeared without a quotient in the last stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(q4) && $stable(mag2) && $stable(average))
    else $error("scaling pipeline moved while stalled");
`endif

endmodule

// ----- hdl/calibrated_moving_average_reporter_core.sv -----
// Calibrated moving-average reporter.
// The tick channel carries one 10-bit ADC sample per transaction. The block keeps a
// boxcar window of WINDOW samples; every second tick shifts the sample in. Every
// report_interval ticks, and only while report_enable is set, the report channel
// delivers one transaction: (window sum * gain) / WINDOW + offset in signed Q16.16,
// clamped to 32 bits, taken from the window as it stood before that tick's shift.
// The settings port (cfg_write, cfg_index, cfg_data) writes gain, offset,
// report_interval and report_enable; write them only while no report is in flight.
// Throughput is one tick per cycle while reports are not stalled. After its tick is
// accepted, a report passes through one capture stage, the sum-times-gain multiplier,
// the partial products of the reciprocal that divides by WINDOW, the quotient add, and
// the offset/clamp stage feeding the output register.
// Reset (rst, synchronous) clears the counters, empties the pipeline and restores
// the settings to their defaults; the first tick after reset fills the whole window
// with its own sample. While the receiver holds report.ready low with a report
// waiting, the whole pipeline freezes and tick.ready stays low.
module calibrated_moving_average_reporter_core #(
  parameter int WINDOW = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  cmar_pkg::cfg_index_t             cfg_index,
  input  logic [cmar_pkg::CFG_W-1:0]       cfg_data,
  cmar_tick_if.sink                        tick,
  cmar_report_if.source                    report
);

  localparam int SUM_W = $clog2(WINDOW*1023+1);
  localparam logic [SUM_W-1:0] WIN_K = SUM_W'(WINDOW);

  // Settings registers.
  logic signed [cmar_pkg::GAIN_W-1:0] gain;
  logic signed [cmar_pkg::OFF_W-1:0]  offset;
  logic [cmar_pkg::INTV_W-1:0]        report_interval;
  logic                               report_enable;

  // Filter state. The window and its sum are only read after the first tick has
  // filled them, so they carry no reset.
  logic [cmar_pkg::RAW_W-1:0]         win [WINDOW];
  logic [SUM_W-1:0]                   sum;
  logic [cmar_pkg::INTV_W-1:0]        report_count;
  logic                               phase;
  logic                               primed;

  logic [cmar_pkg::RAW_W-1:0]         base_win [WINDOW];
  logic [SUM_W-1:0]                   base_sum;
  logic [SUM_W-1:0]                   shift_sum;
  logic [cmar_pkg::INTV_W-1:0]        count_inc;
  logic [cmar_pkg::INTV_W-1:0]        report_count_next;
  logic                               hit;
  logic                               accept;
  logic                               adv;
  logic                               emit;
  cmar_pkg::cal_t                     cal;

  // The whole pipeline moves whenever the output register is empty or being taken.
  assign adv        = !report.valid || report.ready;
  assign tick.ready = adv;
  assign accept     = tick.valid && tick.ready;

  // Before the first tick the window behaves as if it were full of this sample.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      base_win[i] = primed ? win[i] : tick.raw_sample;
    end
    base_sum  = primed ? sum : SUM_W'(tick.raw_sample) * WIN_K;
    shift_sum = base_sum - SUM_W'(base_win[0]) + SUM_W'(tick.raw_sample);
    count_inc = report_count + 1'b1;
    hit       = count_inc >= report_interval;
    report_count_next = hit ? (count_inc - report_interval) : count_inc;
    emit      = accept && hit && report_enable;
    cal.gain   = gain;
    cal.offset = offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= cmar_pkg::GAIN_RESET;
      offset          <= cmar_pkg::OFFSET_RESET;
      report_interval <= cmar_pkg::INTERVAL_RESET;
      report_enable   <= cmar_pkg::ENABLE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cmar_pkg::CFG_GAIN:     gain            <= cfg_data[cmar_pkg::GAIN_W-1:0];
        cmar_pkg::CFG_OFFSET:   offset          <= cfg_data[cmar_pkg::OFF_W-1:0];
        cmar_pkg::CFG_INTERVAL: report_interval <= cfg_data[cmar_pkg::INTV_W-1:0];
        cmar_pkg::CFG_ENABLE:   report_enable   <= cfg_data[0];
      endcase
    end
  end

  // Counters. The sample counter only ever holds zero or one, so it is a phase bit:
  // the sample enters the window on every tick that finds the phase set.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_count <= '0;
      phase        <= 1'b0;
      primed       <= 1'b0;
    end else if (accept) begin
      report_count <= report_count_next;
      phase        <= ~phase;
      primed       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (phase) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          win[i] <= base_win[i+1];
        end
        win[WINDOW-1] <= tick.raw_sample;
        sum           <= shift_sum;
      end else begin
        for (int i = 0; i < WINDOW; i++) begin
          win[i] <= base_win[i];
        end
        sum <= base_sum;
      end
    end
  end

  // The report uses the sum from before this tick's shift.
  cmar_calib #(
    .WINDOW (WINDOW)
  ) u_calib (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (emit),
    .sum       (base_sum),
    .cal       (cal),
    .out_valid (report.valid),
    .average   (report.average)
  );

`ifndef SYNTHESIS
  a_phase_toggles: assert property (@(posedge clk) disable iff (rst)
    accept |=> phase != $past(phase))
    else $error("sample phase did not advance on an accepted tick");

  a_unprimed_idle: assert property (@(posedge clk) disable iff (rst)
    !primed |-> report_count == '0 && !phase)
    else $error("counters moved before the first tick");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    report.valid && !report.ready |-> !tick.ready)
    else $error("tick taken while a report is stalled");
`endif

endmodule
